@@ rtl/core/kdb_pkg.sv @@
// Shared types and constants for the key debouncer.
// No dependencies; imported by every module of the block.
package kdb_pkg;

    localparam int PinW  = 4;
    localparam int CntW  = 16;
    localparam int HoldW = 17;

    localparam logic [CntW-1:0] DebounceReset = 16'd900;
    localparam logic [CntW-1:0] LongReset     = 16'd50000;

    localparam logic ADDR_DEBOUNCE = 1'b0;
    localparam logic ADDR_LONG     = 1'b1;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_WAIT  = 3'd1,
        PH_DLY   = 3'd2,
        PH_CHECK = 3'd3,
        PH_LONG  = 3'd4,
        PH_UP    = 3'd5
    } phase_t;

    typedef struct packed {
        logic [PinW-1:0] key_mask;
        logic            long_press;
    } kdb_event_t;

    typedef struct packed {
        logic [CntW-1:0] debounce_ticks;
        logic [CntW-1:0] long_press_ticks;
    } kdb_cfg_t;

endpackage

@@ rtl/core/key_debounce_short_long_press.sv @@
// Key debouncer with short- and long-press events.
// Depends on kdb_pkg, kdb_cfg, kdb_fsm and kdb_out_fifo.
//
// Usage: each transfer on the s_ channel is one tick carrying four
// active-low key pins in s_tdata[3:0] (up, set, down, menu). A press that
// survives the debounce wait produces one transfer on the m_ channel:
// m_tdata[3:0] is the pressed key mask, m_tuser is 1 for a long press
// (held past long_press_ticks) and 0 for a short press on full release.
// Ticks that end in no event produce no transfer.
// Registers over APB: 0x0 debounce_ticks, 0x4 long_press_ticks (16 bit);
// write them only while no tick is in flight.
// Timing: a tick lands in an input register and is stepped through the state
// machine once the result buffer has room; its event is written into the
// result buffer in that step and shows on m_ from there. One tick per cycle
// is accepted while the result buffer has room; the rate is set by the
// state update.
// A two-entry result buffer absorbs receiver stalls; input stalls only once
// both entries and the input register are occupied.
// Reset (aresetn low, synchronous) restores the register defaults 900 and
// 50000, returns to the start phase and empties all buffers.
module key_debounce_short_long_press (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] raw_pins, [7:4] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] key_mask, [7:4] zero
    output logic        m_tuser,   // [0] long_press
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kdb_pkg::*;

    kdb_cfg_t        cfg;
    logic            in_valid_reg;
    logic [PinW-1:0] pins_reg;
    logic            step;
    logic            evt_valid;
    kdb_event_t      evt;
    logic            has_room;
    kdb_event_t      out_evt;

    kdb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a tick is stepped only when a result, if any, has a slot to go to
    assign step     = in_valid_reg & has_room;
    assign s_tready = ~in_valid_reg | step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) pins_reg <= s_tdata[PinW-1:0];
    end

    kdb_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .raw_pins  (pins_reg),
        .cfg       (cfg),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    kdb_out_fifo u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (evt_valid),
        .wr_data  (evt),
        .has_room (has_room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_evt)
    );

    assign m_tdata = {4'd0, out_evt.key_mask};
    assign m_tuser = out_evt.long_press;

endmodule

@@ rtl/core/kdb_cfg.sv @@
// APB register file holding the debounce and long-press limits.
// Depends on kdb_pkg.
module kdb_cfg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output kdb_pkg::kdb_cfg_t cfg
);
    import kdb_pkg::*;

    logic [CntW-1:0] debounce_reg;
    logic [CntW-1:0] long_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DebounceReset;
            long_reg     <= LongReset;
        end else if (wr_en) begin
            unique case (paddr[2])
                ADDR_DEBOUNCE: debounce_reg <= pwdata[CntW-1:0];
                ADDR_LONG:     long_reg     <= pwdata[CntW-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ADDR_DEBOUNCE: prdata = {16'd0, debounce_reg};
            ADDR_LONG:     prdata = {16'd0, long_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.debounce_ticks   = debounce_reg;
    assign cfg.long_press_ticks = long_reg;

endmodule

@@ rtl/core/kdb_fsm.sv @@
// Debounce and press-length state machine, one tick per step.
// Depends on kdb_pkg.
module kdb_fsm (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [3:0]            raw_pins,
    input  kdb_pkg::kdb_cfg_t     cfg,
    output logic                  evt_valid,
    output kdb_pkg::kdb_event_t   evt
);
    import kdb_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CntW-1:0]  deb_reg, deb_next;
    logic [HoldW-1:0] hold_reg, hold_next;
    logic [PinW-1:0]  saved_reg, saved_next;
    logic [PinW-1:0]  mask;
    logic [CntW-1:0]  deb_inc;
    logic [HoldW-1:0] hold_inc;

    assign mask     = ~raw_pins;
    assign deb_inc  = deb_reg + 1'b1;
    assign hold_inc = hold_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            deb_reg   <= '0;
            hold_reg  <= '0;
            saved_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            deb_reg   <= deb_next;
            hold_reg  <= hold_next;
            saved_reg <= saved_next;
        end
    end

    // next state and counters
    always_comb begin
        phase_next = phase_reg;
        deb_next   = deb_reg;
        hold_next  = hold_reg;
        saved_next = saved_reg;
        unique case (phase_reg)
            PH_WAIT: begin
                if (mask != '0) begin
                    saved_next = mask;
                    phase_next = PH_DLY;
                end
            end
            PH_DLY: begin
                deb_next = deb_inc;
                if (deb_inc >= cfg.debounce_ticks) begin
                    deb_next   = '0;
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                phase_next = (mask == saved_reg) ? PH_LONG : PH_START;
            end
            PH_LONG: begin
                if (mask == saved_reg) begin
                    hold_next = hold_inc;
                    if (hold_inc > {1'b0, cfg.long_press_ticks}) begin
                        hold_next  = '0;
                        phase_next = PH_UP;
                    end
                end else begin
                    phase_next = PH_START;
                end
            end
            PH_UP: begin
                if (mask != saved_reg) phase_next = PH_START;
            end
            default: begin
                // start and unused codes read the keys in the same tick
                deb_next   = '0;
                hold_next  = '0;
                phase_next = PH_WAIT;
                if (mask != '0) begin
                    saved_next = mask;
                    phase_next = PH_DLY;
                end
            end
        endcase
    end

    // event outputs
    always_comb begin
        evt_valid      = 1'b0;
        evt.key_mask   = saved_reg;
        evt.long_press = 1'b0;
        if (step && phase_reg == PH_LONG) begin
            if (mask == saved_reg) begin
                if (hold_inc > {1'b0, cfg.long_press_ticks}) begin
                    evt_valid      = 1'b1;
                    evt.long_press = 1'b1;
                end
            end else if (mask == '0) begin
                evt_valid = 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/kdb_out_fifo.sv @@
// Two-entry result buffer that decouples the state machine from the receiver.
// Depends on kdb_pkg.
module kdb_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  kdb_pkg::kdb_event_t wr_data,
    output logic                has_room,
    output logic                rd_valid,
    input  logic                rd_ready,
    output kdb_pkg::kdb_event_t rd_data
);
    import kdb_pkg::*;

    kdb_event_t mem_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       rd_en;

    assign rd_valid = count_reg != 2'd0;
    assign has_room = count_reg != 2'd2;
    assign rd_en    = rd_valid & rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en)      count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (wr_en) wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en) rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for key_debounce_short_long_press: key ticks in, press events out.
// Depends on kdb_pkg and the block RTL; expected events come from a debounce model kept here.
module tb;
    import kdb_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 6;      // margin for events still in flight
    localparam int STALL_LIMIT   = 2000;   // cycles with no transfer at all
    localparam int HOLD_OFF      = 400;

    localparam logic [2:0] DEBOUNCE_ADDR = {ADDR_DEBOUNCE, 2'b00};
    localparam logic [2:0] LONG_ADDR     = {ADDR_LONG, 2'b00};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [3:0] raw_pins, [7:4] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;    // [3:0] key_mask, [7:4] zero
    logic        m_tuser;    // [0] long_press
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // debounce model state
    phase_t          kb_phase;
    logic [15:0]     kb_deb;
    logic [16:0]     kb_hold;
    logic [3:0]      kb_saved;
    kdb_cfg_t        kb_cfg;
    kdb_event_t      press_events_due[$];

    int  err_count    = 0;
    int  ticks_taken  = 0;
    int  short_seen   = 0;
    int  long_seen    = 0;
    int  stall_cycles = 0;
    int  rx_gap       = 0;
    int  rx_hold_left = 0;
    bit  tx_idle_en   = 1'b0;
    bit  rx_idle_en   = 1'b0;

    key_debounce_short_long_press DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one key tick through the debouncer; fired marks an event
    function automatic void debounce_step(input logic [3:0] pins, output logic fired,
                                          output kdb_event_t evt);
        logic [3:0] pressed;
        pressed = ~pins;
        fired = 1'b0;
        evt = '0;
        case (kb_phase)
            PH_WAIT: begin
                if (pressed != 4'h0) begin
                    kb_saved = pressed;
                    kb_phase = PH_DLY;
                end
            end
            PH_DLY: begin
                kb_deb = kb_deb + 16'd1;
                if (kb_deb >= kb_cfg.debounce_ticks) begin
                    kb_deb = '0;
                    kb_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (pressed == kb_saved)
                    kb_phase = PH_LONG;
                else
                    kb_phase = PH_START;
            end
            PH_LONG: begin
                if (pressed == kb_saved) begin
                    kb_hold = kb_hold + 17'd1;
                    if (kb_hold > {1'b0, kb_cfg.long_press_ticks}) begin
                        kb_hold = '0;
                        fired = 1'b1;
                        evt.key_mask = kb_saved;
                        evt.long_press = 1'b1;
                        kb_phase = PH_UP;
                    end
                end else begin
                    // full release reports a short press, partial change is dropped
                    if (pressed == 4'h0) begin
                        fired = 1'b1;
                        evt.key_mask = kb_saved;
                        evt.long_press = 1'b0;
                    end
                    kb_phase = PH_START;
                end
            end
            PH_UP: begin
                if (pressed != kb_saved)
                    kb_phase = PH_START;
            end
            default: begin
                kb_deb = '0;
                kb_hold = '0;
                kb_phase = PH_WAIT;
                if (pressed != 4'h0) begin
                    kb_saved = pressed;
                    kb_phase = PH_DLY;
                end
            end
        endcase
    endfunction

    // event check first, then predict from the accepted tick
    always @(posedge aclk) begin : scoreboard
        kdb_event_t want;
        kdb_event_t evt;
        logic       fired;
        if (aresetn && m_tvalid && m_tready) begin
            if (press_events_due.size() == 0) begin
                $error("unexpected event: key_mask %h long_press %b", m_tdata[3:0], m_tuser);
                err_count++;
            end else begin
                want = press_events_due.pop_front();
                if (m_tdata[3:0] !== want.key_mask) begin
                    $error("key_mask: expected %h, actual %h", want.key_mask, m_tdata[3:0]);
                    err_count++;
                end
                if (m_tuser !== want.long_press) begin
                    $error("long_press: expected %b, actual %b", want.long_press, m_tuser);
                    err_count++;
                end
                if (want.long_press)
                    long_seen++;
                else
                    short_seen++;
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            ticks_taken++;
            debounce_step(s_tdata[3:0], fired, evt);
            if (fired)
                press_events_due.push_back(evt);
        end
    end

    // event receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap <= 0;
        end else if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (rx_idle_en)
                rx_gap <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic [3:0] pins);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, pins};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic hold_keys(input logic [3:0] mask, input int n);
        repeat (n) send_tick(~mask);
    endtask

    // stop offering ticks, collect every pending event, let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (press_events_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_setting(input logic [2:0] addr, input logic [15:0] want,
                                  input string name);
        logic [31:0] rd;
        apb_cycle(1'b0, addr, 32'h0, rd);
        if (rd !== {16'h0, want}) begin
            $error("%s readback: expected %0d, actual %0d", name, want, rd);
            err_count++;
        end
    endtask

    task automatic write_setting(input logic sel, input logic [15:0] value);
        logic [31:0] unused_rd;
        logic [2:0]  addr;
        addr = {sel, 2'b00};
        apb_cycle(1'b1, addr, {16'h0, value}, unused_rd);
        if (sel == ADDR_DEBOUNCE) begin
            kb_cfg.debounce_ticks = value;
            verify_setting(addr, value, "debounce_ticks");
        end else begin
            kb_cfg.long_press_ticks = value;
            verify_setting(addr, value, "long_press_ticks");
        end
    endtask

    task automatic configure(input logic [15:0] deb, input logic [15:0] lng);
        write_setting(ADDR_DEBOUNCE, deb);
        write_setting(ADDR_LONG, lng);
    endtask

    task automatic test_register_defaults();
        verify_setting(DEBOUNCE_ADDR, DebounceReset, "debounce_ticks");
        verify_setting(LONG_ADDR, LongReset, "long_press_ticks");
    endtask

    // keys down for part of the reset debounce wait, then released: no event yet
    task automatic test_default_timing();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_keys(4'hF, 40);
        hold_keys(4'h0, 2);
        settle();
    endtask

    task automatic test_press_cases();
        configure(16'd0, 16'd1);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_keys(4'h0, 2);
        // each key alone, released during the hold count
        for (int k = 0; k < 4; k++) begin
            hold_keys(4'h1 << k, 4);
            hold_keys(4'h0, 1);
        end
        // mask changes right at the post-debounce compare
        hold_keys(4'h3, 2);
        hold_keys(4'h1, 1);
        // partial release while holding: no event
        hold_keys(4'h6, 4);
        hold_keys(4'h2, 1);
        // held past the limit, then sits in the wait-for-change phase
        hold_keys(4'hF, 6);
        hold_keys(4'h0, 1);
        settle();
    endtask

    // largest register values read back, then a debounce wait just long enough
    task automatic test_debounce_limit();
        configure(16'hFFFF, 16'hFFFF);
        configure(16'd40, 16'd0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_keys(4'h5, 44);
        hold_keys(4'h0, 2);
        settle();
    endtask

    // hold counter passes the limit before the event fires
    task automatic test_hold_limit();
        configure(16'd0, 16'd50);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_keys(4'hA, 56);
        hold_keys(4'h0, 2);
        settle();
    endtask

    // receiver stalls while long presses keep coming; sender then waits for all
    task automatic test_backpressure();
        configure(16'd0, 16'd0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_left = HOLD_OFF;
        repeat (15) begin
            hold_keys(4'($urandom_range(1, 15)), 5);
            hold_keys(4'h0, 1);
        end
        settle();
    endtask

    task automatic random_press_burst(input int hold_max);
        logic [3:0] mask;
        int         kind;
        kind = $urandom_range(0, 9);
        tx_idle_en = ($urandom_range(0, 4) != 0);
        rx_idle_en = ($urandom_range(0, 4) != 0);
        if (kind < 2) begin
            repeat ($urandom_range(1, 6)) send_tick(4'($urandom_range(0, 15)));
        end else begin
            mask = 4'($urandom_range(1, 15));
            hold_keys(mask, $urandom_range(1, hold_max));
            if (kind < 7)
                hold_keys(4'h0, $urandom_range(1, 3));
            else if (kind < 9)
                hold_keys(4'($urandom_range(1, 15)), $urandom_range(1, 2));
        end
    endtask

    task automatic test_random_traffic();
        int first;
        int hold_max;
        for (int s = 0; s < 5; s++) begin
            if (s == 0)
                configure(16'd0, 16'd0);
            else
                configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)));
            hold_max = int'(kb_cfg.debounce_ticks) + int'(kb_cfg.long_press_ticks) + 6;
            first = ticks_taken;
            do
                random_press_burst(hold_max);
            while ((ticks_taken - first < 50) || (s == 4 && short_seen + long_seen < 40));
            settle();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'h0;
        kb_phase = PH_START;
        kb_deb = '0;
        kb_hold = '0;
        kb_saved = '0;
        kb_cfg.debounce_ticks = DebounceReset;
        kb_cfg.long_press_ticks = LongReset;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_defaults();
        test_default_timing();
        test_press_cases();
        test_debounce_limit();
        test_hold_limit();
        test_backpressure();
        test_random_traffic();

        $display("Ran %0d key ticks, %0d short and %0d long press events checked,",
                 ticks_taken, short_seen, long_seen);
        $display("with debounce and hold limits from 0 to 50, full-range readback and stalls.");
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ key_debounce_short_long_press.f @@
rtl/core/kdb_pkg.sv
rtl/core/kdb_cfg.sv
rtl/core/kdb_fsm.sv
rtl/core/kdb_out_fifo.sv
rtl/core/key_debounce_short_long_press.sv
tb/sv/tb.sv
